// File: rtl/bpt_pkg.sv
// ----------------------------------------------------------------------------
// bpt_pkg
// Widths, register indexes and shared types of the barometer compensation.
// ----------------------------------------------------------------------------
package bpt_pkg;

  localparam int RAW_W    = 24;  // raw conversion words
  localparam int COEFF_W  = 16;  // calibration words
  localparam int DT_W     = 25;  // temperature difference, signed
  localparam int PROD_W   = 42;  // dT times a calibration word, signed
  localparam int SQ_W     = 50;  // dT squared, signed container
  localparam int TEMP_W   = 19;  // output temperature
  localparam int TWIDE_W  = 20;  // temperature before saturation
  localparam int T2_W     = 17;  // second-order temperature term
  localparam int LOW_W    = 36;  // squared low-temperature terms
  localparam int CORR_W   = 39;  // second-order offset / sensitivity terms
  localparam int OFF_W    = 40;  // offset, signed
  localparam int SENS_W   = 39;  // sensitivity, signed
  localparam int SLO_W    = 20;  // low slice of sensitivity for the split product
  localparam int SHI_W    = SENS_W - SLO_W;
  localparam int PLO_W    = RAW_W + SLO_W;
  localparam int PHI_W    = RAW_W + 1 + SHI_W;
  localparam int PFULL_W  = 64;  // full pressure product, signed
  localparam int DIFF_W   = 44;  // scaled product minus offset, signed
  localparam int PWIDE_W  = DIFF_W - 15;
  localparam int PRESS_W  = 24;  // output pressure
  localparam int NSTG     = 9;   // pipeline register stages

  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SENS     = 3'd0;
  localparam logic [2:0] REG_OFF      = 3'd1;
  localparam logic [2:0] REG_SENS_TC  = 3'd2;
  localparam logic [2:0] REG_OFF_TC   = 3'd3;
  localparam logic [2:0] REG_TREF     = 3'd4;
  localparam logic [2:0] REG_TSLOPE   = 3'd5;

  localparam logic signed [TWIDE_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [TWIDE_W-1:0] TEMP_VLOW = -20'sd1500;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] off;
    logic [COEFF_W-1:0] sens_tc;
    logic [COEFF_W-1:0] off_tc;
    logic [COEFF_W-1:0] tref;
    logic [COEFF_W-1:0] tslope;
  } bpt_coeff_t;

endpackage

// File: rtl/bpt_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpt_cfg_regs
// APB register file holding the six calibration words.
// ----------------------------------------------------------------------------
module bpt_cfg_regs
  import bpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output bpt_coeff_t        coeff
);

  bpt_coeff_t       coeff_r;
  bpt_coeff_t       coeff_nxt;
  logic [2:0]       idx;
  logic             wr_en;
  logic [COEFF_W-1:0] wval;
  logic [COEFF_W-1:0] rval;

  assign idx   = paddr[APB_AW-1:2];
  assign wr_en = psel && penable && pwrite;
  assign wval  = pwdata[COEFF_W-1:0];

  always_comb begin
    coeff_nxt = coeff_r;
    if (wr_en) begin
      case (idx)
        REG_SENS:    coeff_nxt.sens    = wval;
        REG_OFF:     coeff_nxt.off     = wval;
        REG_SENS_TC: coeff_nxt.sens_tc = wval;
        REG_OFF_TC:  coeff_nxt.off_tc  = wval;
        REG_TREF:    coeff_nxt.tref    = wval;
        REG_TSLOPE:  coeff_nxt.tslope  = wval;
        default:     coeff_nxt = coeff_r;  // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else begin
      coeff_r <= coeff_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_SENS:    rval = coeff_r.sens;
      REG_OFF:     rval = coeff_r.off;
      REG_SENS_TC: rval = coeff_r.sens_tc;
      REG_OFF_TC:  rval = coeff_r.off_tc;
      REG_TREF:    rval = coeff_r.tref;
      REG_TSLOPE:  rval = coeff_r.tslope;
      default:     rval = '0;
    endcase
  end

  assign prdata = {{(APB_DW-COEFF_W){1'b0}}, rval};
  assign coeff  = coeff_r;

endmodule

// File: rtl/baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order barometer compensation: raw pressure and temperature words in,
// temperature (0.01 deg) and pressure (0.01 mbar) out.
// ----------------------------------------------------------------------------
// Takes one raw pressure/temperature request per clock and returns its result
// through a nine-stage pipeline: temperature difference, calibration products,
// first-order terms, low-temperature squares, second-order corrections,
// corrected offset and sensitivity, the pressure-by-sensitivity product split
// into two partial products, their sum, and the final scale and saturate.
// Throughput is one request per cycle; a stalled output holds the last stage
// and every full stage directly behind it, while empty stages upstream keep
// taking requests. Load the calibration words over APB while no request is in
// flight.
module baro_pressure_temp_compensation
  import bpt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [RAW_W-1:0]          in_raw_pressure,
  input  logic [RAW_W-1:0]          in_raw_temperature,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [TEMP_W-1:0]  out_temp_centideg,
  output logic signed [PRESS_W-1:0] out_press_centimbar,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  bpt_coeff_t        coeff;
  logic [NSTG-1:0]   v_r;
  logic [NSTG-1:0]   v_nxt;
  logic [NSTG-1:0]   en;

  // stage A
  logic signed [DT_W-1:0]    dt_a_nxt, dt_a_r;
  logic [RAW_W-1:0]          d1_a_r;
  // stage B
  logic signed [PROD_W-1:0]  pslope_b_nxt, poff_b_nxt, psens_b_nxt;
  logic signed [PROD_W-1:0]  pslope_b_r, poff_b_r, psens_b_r;
  logic signed [SQ_W-1:0]    sq_b_nxt, sq_b_r;
  logic [RAW_W-1:0]          d1_b_r;
  // stage C
  logic signed [TWIDE_W-1:0] temp1_c_nxt, temp1_c_r;
  logic signed [OFF_W-1:0]   off1_c_nxt, off1_c_r;
  logic signed [SENS_W-1:0]  sens1_c_nxt, sens1_c_r;
  logic [T2_W-1:0]           t2_c_r;
  logic [RAW_W-1:0]          d1_c_r;
  // stage D
  logic signed [TWIDE_W-1:0] dl_d, dv_d;
  logic signed [2*TWIDE_W-1:0] dl_sq_d, dv_sq_d;
  logic signed [TWIDE_W-1:0] temp1_d_r;
  logic                      lt_d_r, lv_d_r;
  logic [LOW_W-1:0]          low_d_r, vlow_d_r;
  logic [T2_W-1:0]           t2_d_r;
  logic signed [OFF_W-1:0]   off1_d_r;
  logic signed [SENS_W-1:0]  sens1_d_r;
  logic [RAW_W-1:0]          d1_d_r;
  // stage E
  logic [CORR_W-1:0]         low5_e, vlow7_e, vlow11_e;
  logic [CORR_W-1:0]         off2_e_nxt, sens2_e_nxt;
  logic signed [TWIDE_W-1:0] tw_e;
  logic signed [TEMP_W-1:0]  temp_e_nxt;
  logic signed [TEMP_W-1:0]  temp_e_r;
  logic [CORR_W-1:0]         off2_e_r, sens2_e_r;
  logic signed [OFF_W-1:0]   off1_e_r;
  logic signed [SENS_W-1:0]  sens1_e_r;
  logic [RAW_W-1:0]          d1_e_r;
  // stage F
  logic signed [TEMP_W-1:0]  temp_f_r;
  logic signed [OFF_W-1:0]   off_f_nxt, off_f_r;
  logic signed [SENS_W-1:0]  sens_f_nxt, sens_f_r;
  logic [RAW_W-1:0]          d1_f_r;
  // stage G
  logic signed [TEMP_W-1:0]  temp_g_r;
  logic signed [OFF_W-1:0]   off_g_r;
  logic [PLO_W-1:0]          plo_g_nxt, plo_g_r;
  logic signed [PHI_W-1:0]   phi_g_nxt, phi_g_r;
  // stage H
  logic signed [TEMP_W-1:0]  temp_h_r;
  logic signed [OFF_W-1:0]   off_h_r;
  logic signed [PFULL_W-1:0] prod_h_nxt, prod_h_r;
  // stage I
  logic signed [DIFF_W-1:0]  diff_i;
  logic signed [PWIDE_W-1:0] pw_i;
  logic signed [PRESS_W-1:0] press_i_nxt, press_i_r;
  logic signed [TEMP_W-1:0]  temp_i_r;

  logic in_fire;
  logic out_fire;

  bpt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coeff   (coeff)
  );

  assign pready = 1'b1;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NSTG-1];
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // ---- datapath, next values ----
  always_comb begin
    dt_a_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, coeff.tref, 8'b0});

    pslope_b_nxt = dt_a_r * $signed({1'b0, coeff.tslope});
    poff_b_nxt   = dt_a_r * $signed({1'b0, coeff.off_tc});
    psens_b_nxt  = dt_a_r * $signed({1'b0, coeff.sens_tc});
    sq_b_nxt     = dt_a_r * dt_a_r;

    temp1_c_nxt = TEMP_REF + $signed(pslope_b_r[PROD_W-1:23]);
    off1_c_nxt  = $signed({8'b0, coeff.off, 16'b0})
                + $signed({{5{poff_b_r[PROD_W-1]}}, poff_b_r[PROD_W-1:7]});
    sens1_c_nxt = $signed({8'b0, coeff.sens, 15'b0})
                + $signed({{5{psens_b_r[PROD_W-1]}}, psens_b_r[PROD_W-1:8]});

    dl_d    = temp1_c_r - TEMP_REF;
    dv_d    = temp1_c_r - TEMP_VLOW;
    dl_sq_d = dl_d * dl_d;
    dv_sq_d = dv_d * dv_d;

    // second-order terms; all are non-negative, so plain shifts floor them
    low5_e   = ({3'b0, low_d_r} << 2) + {3'b0, low_d_r};
    vlow7_e  = ({3'b0, vlow_d_r} << 3) - {3'b0, vlow_d_r};
    vlow11_e = ({3'b0, vlow_d_r} << 3) + ({3'b0, vlow_d_r} << 1) + {3'b0, vlow_d_r};
    off2_e_nxt  = (low5_e >> 1) + (lv_d_r ? vlow7_e : '0);
    sens2_e_nxt = (low5_e >> 2) + (lv_d_r ? (vlow11_e >> 1) : '0);
    if (!lt_d_r) begin
      off2_e_nxt  = '0;
      sens2_e_nxt = '0;
    end
    tw_e = lt_d_r ? (temp1_d_r - $signed({3'b0, t2_d_r})) : temp1_d_r;
    if (tw_e[TWIDE_W-1] != tw_e[TEMP_W-1]) begin
      temp_e_nxt = tw_e[TWIDE_W-1] ? {1'b1, {(TEMP_W-1){1'b0}}}
                                   : {1'b0, {(TEMP_W-1){1'b1}}};
    end else begin
      temp_e_nxt = tw_e[TEMP_W-1:0];
    end

    off_f_nxt  = off1_e_r - $signed({1'b0, off2_e_r});
    sens_f_nxt = sens1_e_r - $signed({1'b0, sens2_e_r[SENS_W-2:0]});

    plo_g_nxt = d1_f_r * sens_f_r[SLO_W-1:0];
    phi_g_nxt = $signed({1'b0, d1_f_r}) * $signed(sens_f_r[SENS_W-1:SLO_W]);

    prod_h_nxt = $signed({phi_g_r[PFULL_W-SLO_W-1:0], {SLO_W{1'b0}}})
               + $signed({{(PFULL_W-PLO_W){1'b0}}, plo_g_r});

    diff_i = $signed(prod_h_r[PFULL_W-1:21]) - off_h_r;
    pw_i   = diff_i[DIFF_W-1:15];
    if (pw_i[PWIDE_W-1:PRESS_W-1] != {(PWIDE_W-PRESS_W+1){pw_i[PWIDE_W-1]}}) begin
      press_i_nxt = pw_i[PWIDE_W-1] ? {1'b1, {(PRESS_W-1){1'b0}}}
                                    : {1'b0, {(PRESS_W-1){1'b1}}};
    end else begin
      press_i_nxt = pw_i[PRESS_W-1:0];
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt_a_r <= dt_a_nxt;
      d1_a_r <= in_raw_pressure;
    end
    if (en[1]) begin
      pslope_b_r <= pslope_b_nxt;
      poff_b_r   <= poff_b_nxt;
      psens_b_r  <= psens_b_nxt;
      sq_b_r     <= sq_b_nxt;
      d1_b_r     <= d1_a_r;
    end
    if (en[2]) begin
      temp1_c_r <= temp1_c_nxt;
      off1_c_r  <= off1_c_nxt;
      sens1_c_r <= sens1_c_nxt;
      t2_c_r    <= sq_b_r[47:31];
      d1_c_r    <= d1_b_r;
    end
    if (en[3]) begin
      temp1_d_r <= temp1_c_r;
      lt_d_r    <= dl_d[TWIDE_W-1];
      lv_d_r    <= dv_d[TWIDE_W-1];
      low_d_r   <= dl_sq_d[LOW_W-1:0];
      vlow_d_r  <= dv_sq_d[LOW_W-1:0];
      t2_d_r    <= t2_c_r;
      off1_d_r  <= off1_c_r;
      sens1_d_r <= sens1_c_r;
      d1_d_r    <= d1_c_r;
    end
    if (en[4]) begin
      temp_e_r  <= temp_e_nxt;
      off2_e_r  <= off2_e_nxt;
      sens2_e_r <= sens2_e_nxt;
      off1_e_r  <= off1_d_r;
      sens1_e_r <= sens1_d_r;
      d1_e_r    <= d1_d_r;
    end
    if (en[5]) begin
      temp_f_r <= temp_e_r;
      off_f_r  <= off_f_nxt;
      sens_f_r <= sens_f_nxt;
      d1_f_r   <= d1_e_r;
    end
    if (en[6]) begin
      temp_g_r <= temp_f_r;
      off_g_r  <= off_f_r;
      plo_g_r  <= plo_g_nxt;
      phi_g_r  <= phi_g_nxt;
    end
    if (en[7]) begin
      temp_h_r <= temp_g_r;
      off_h_r  <= off_g_r;
      prod_h_r <= prod_h_nxt;
    end
    if (en[8]) begin
      temp_i_r  <= temp_h_r;
      press_i_r <= press_i_nxt;
    end
  end

  assign out_temp_centideg   = temp_i_r;
  assign out_press_centimbar = press_i_r;

  // ---- assertions ----
  a_occupancy_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !out_fire) |=> ($countones(v_r) == $past($countones(v_r)) + 1))
    else $error("request entered but pipeline occupancy did not grow");

  a_occupancy_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !in_fire) |=> ($countones(v_r) + 1 == $past($countones(v_r))))
    else $error("result left but pipeline occupancy did not shrink");

  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ((&v_r) && !out_ready))
    else $error("input stalled while a pipeline stage is free");

endmodule

// File: sim/baro_pressure_temp_compensation_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_test
// Drives raw pressure/temperature requests through the barometer compensation
// block under several calibration sets and checks every temperature and
// pressure result against a cycle-free integer predictor or a fixed expected
// reading, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_test;
  import bpt_pkg::*;

  typedef struct packed {
    logic signed [TEMP_W-1:0]  temp;
    logic signed [PRESS_W-1:0] press;
  } reading_t;

  typedef struct packed {
    logic [2:0]       cal;
    logic [RAW_W-1:0] p;
    logic [RAW_W-1:0] t;
    logic             known;
    reading_t         want;
  } probe_t;

  typedef enum {ALWAYS_READY, COIN_FLIP, SPARSE, DUTY_CYCLE} sink_mode_t;

  localparam logic [2:0] REG_SPARE    = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam logic [2:0] REG_ORDER [6] = '{REG_SENS, REG_OFF, REG_SENS_TC, REG_OFF_TC,
                                          REG_TREF, REG_TSLOPE};

  localparam logic [2:0] CAL_RESET   = 3'd0;
  localparam logic [2:0] CAL_TYPICAL = 3'd1;
  localparam logic [2:0] CAL_COLD    = 3'd2;
  localparam logic [2:0] CAL_MAX     = 3'd3;
  localparam logic [2:0] CAL_MIXED   = 3'd4;

  localparam bpt_coeff_t CAL_SETS [5] = '{
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'h0100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h4000}
  };

  // with all calibration words zero the block rests at 20.00 deg and zero pressure
  localparam reading_t AT_REST    = '{19'sd2000, 24'sd0};
  localparam reading_t NO_READING = '0;

  localparam probe_t DIRECTED [21] = '{
    '{CAL_RESET,   24'h000000,  24'h000000,  1'b1, AT_REST},
    '{CAL_RESET,   24'hFFFFFF,  24'hFFFFFF,  1'b1, AT_REST},
    '{CAL_RESET,   24'hFFFFFF,  24'h000000,  1'b1, AT_REST},
    '{CAL_RESET,   24'h000000,  24'hFFFFFF,  1'b1, AT_REST},
    '{CAL_TYPICAL, 24'd9085466, 24'd8569150, 1'b0, NO_READING},
    '{CAL_TYPICAL, 24'h000000,  24'd8569150, 1'b0, NO_READING},
    '{CAL_TYPICAL, 24'hFFFFFF,  24'd8569150, 1'b0, NO_READING},
    '{CAL_TYPICAL, 24'd9085466, 24'h000000,  1'b0, NO_READING},
    '{CAL_TYPICAL, 24'd9085466, 24'hFFFFFF,  1'b0, NO_READING},
    // deepest cold: negative sensitivity, pressure saturates low
    '{CAL_COLD,    24'hFFFFFF,  24'h000000,  1'b0, NO_READING},
    '{CAL_COLD,    24'h000000,  24'h000000,  1'b0, NO_READING},
    '{CAL_COLD,    24'hFFFFFF,  24'd16648960, 1'b0, NO_READING},
    '{CAL_COLD,    24'h800000,  24'hFFFF00,  1'b0, NO_READING},
    '{CAL_COLD,    24'h800000,  24'hFFFEFF,  1'b0, NO_READING},
    '{CAL_MAX,     24'hFFFFFF,  24'hFFFFFF,  1'b0, NO_READING},
    '{CAL_MAX,     24'h000000,  24'h000000,  1'b0, NO_READING},
    '{CAL_MAX,     24'd123456,  24'hFFFF00,  1'b0, NO_READING},
    '{CAL_MAX,     24'hFFFFFF,  24'h000000,  1'b0, NO_READING},
    '{CAL_MIXED,   24'hFFFFFF,  24'h000000,  1'b0, NO_READING},
    '{CAL_MIXED,   24'h5A5A5A,  24'hA5A5A5,  1'b0, NO_READING},
    '{CAL_MIXED,   24'hFFFFFF,  24'h800000,  1'b0, NO_READING}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [RAW_W-1:0]          in_raw_pressure = '0;
  logic [RAW_W-1:0]          in_raw_temperature = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [TEMP_W-1:0]  out_temp_centideg;
  logic signed [PRESS_W-1:0] out_press_centimbar;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  bpt_coeff_t  cal_now = '0;
  reading_t    expected_readings [$];
  int unsigned mismatches = 0;
  int unsigned delivered = 0;

  baro_pressure_temp_compensation DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_raw_pressure     (in_raw_pressure),
    .in_raw_temperature  (in_raw_temperature),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_temp_centideg   (out_temp_centideg),
    .out_press_centimbar (out_press_centimbar),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  function automatic longint saturate(input longint x, input int bits);
    longint top;
    top = (longint'(1) <<< (bits - 1)) - 1;
    if (x > top) return top;
    if (x < -top - 1) return -top - 1;
    return x;
  endfunction

  function automatic reading_t compensate(input bpt_coeff_t c, input logic [RAW_W-1:0] raw_p,
                                          input logic [RAW_W-1:0] raw_t);
    longint d1, dt, tref, slope, k_off, k_sens, k_otc, k_stc;
    longint temp, off, sens, low, vlow, off2, sens2, press;
    reading_t r;
    d1 = raw_p;
    dt = raw_t;
    tref = c.tref;
    slope = c.tslope;
    k_off = c.off;
    k_sens = c.sens;
    k_otc = c.off_tc;
    k_stc = c.sens_tc;
    dt = dt - tref * 256;
    temp = TEMP_REF + ((dt * slope) >>> 23);
    off = (k_off <<< 16) + ((k_otc * dt) >>> 7);
    sens = (k_sens <<< 15) + ((k_stc * dt) >>> 8);
    if (temp < TEMP_REF) begin
      low = (temp - TEMP_REF) * (temp - TEMP_REF);
      off2 = (5 * low) >>> 1;
      sens2 = (5 * low) >>> 2;
      if (temp < TEMP_VLOW) begin
        vlow = (temp - TEMP_VLOW) * (temp - TEMP_VLOW);
        off2 += 7 * vlow;
        sens2 += (11 * vlow) >>> 1;
      end
      off -= off2;
      sens -= sens2;
      temp -= (dt * dt) >>> 31;
    end
    // product is signed: a negative sensitivity drives pressure negative
    press = (((d1 * sens) >>> 21) - off) >>> 15;
    r.temp = TEMP_W'(saturate(temp, TEMP_W));
    r.press = PRESS_W'(saturate(press, PRESS_W));
    return r;
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COEFF_W'($urandom);
    endcase
  endfunction

  function automatic bpt_coeff_t pick_calibration();
    bpt_coeff_t c;
    c.sens = pick_coeff();
    c.off = pick_coeff();
    c.sens_tc = pick_coeff();
    c.off_tc = pick_coeff();
    c.tref = pick_coeff();
    c.tslope = pick_coeff();
    return c;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw_pressure();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // bias toward the reference temperature so both low-temperature branches get hit
  function automatic logic [RAW_W-1:0] pick_raw_temp(input bpt_coeff_t c);
    longint near;
    near = c.tref;
    near = near * 256;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: near = near + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      6: near = near + longint'($urandom_range(0, 1 << 13)) - (1 << 12);
      default: return RAW_W'($urandom);
    endcase
    if (near < 0) near = 0;
    if (near > 64'sh00FF_FFFF) near = 64'sh00FF_FFFF;
    return near[RAW_W-1:0];
  endfunction

  task automatic apb_access(input bit wr, input logic [2:0] idx,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
  endtask

  task automatic load_calibration(input bpt_coeff_t c);
    logic [COEFF_W-1:0] words [6];
    logic [APB_DW-1:0]  rd;
    words = '{c.sens, c.off, c.sens_tc, c.off_tc, c.tref, c.tslope};
    pause_until_drained();
    // upper data bits are don't-care for 16-bit registers
    for (int r = 0; r < 6; r++)
      apb_access(1'b1, REG_ORDER[r], {16'($urandom), words[r]}, rd);
    // writes past the last register are dropped
    apb_access(1'b1, $urandom_range(0, 1) ? REG_SPARE : REG_SPARE_HI, $urandom, rd);
    cal_now = c;
    for (int r = 0; r < 6; r++) begin
      apb_access(1'b0, REG_ORDER[r], '0, rd);
      if (rd[COEFF_W-1:0] !== words[r]) begin
        $display("%0t register %0d readback expected %h got %h", $time, REG_ORDER[r], words[r],
                 rd[COEFF_W-1:0]);
        mismatches++;
      end
    end
  endtask

  task automatic send_request(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t,
                              input logic known, input reading_t typed);
    in_valid <= 1'b1;
    in_raw_pressure <= p;
    in_raw_temperature <= t;
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(known ? typed : compensate(cal_now, p, t));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      delivered++;
      if (expected_readings.size() == 0) begin
        $display("%0t result with none expected: temp %0d press %0d", $time,
                 out_temp_centideg, out_press_centimbar);
        mismatches++;
      end else begin
        if (out_temp_centideg !== expected_readings[0].temp) begin
          $display("%0t temp_centideg expected %0d got %0d", $time,
                   expected_readings[0].temp, out_temp_centideg);
          mismatches++;
        end
        if (out_press_centimbar !== expected_readings[0].press) begin
          $display("%0t press_centimbar expected %0d got %0d", $time,
                   expected_readings[0].press, out_press_centimbar);
          mismatches++;
        end
        void'(expected_readings.pop_front());
      end
    end
  end

  initial begin : receiver
    sink_mode_t  mode;
    int          mode_left;
    int          hold_left;
    bit          held;
    int unsigned tick;
    mode = ALWAYS_READY;
    mode_left = 0;
    hold_left = 0;
    held = 1'b0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && delivered >= 400) begin
        // long hold: let the pipeline fill and back up into the input
        held = 1'b1;
        hold_left = 150;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          ALWAYS_READY: out_ready <= 1'b1;
          COIN_FLIP:    out_ready <= 1'($urandom_range(0, 1));
          SPARSE:       out_ready <= ($urandom_range(0, 3) == 0);
          default:      out_ready <= tick[2];
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL baro_pressure_temp_compensation");
    $finish;
  end

  initial begin
    logic [2:0] cal_loaded;
    bpt_coeff_t next_cal;
    int         burst;
    int         gap;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cal_loaded = CAL_RESET;
    for (int k = 0; k < $size(DIRECTED); k++) begin
      if (DIRECTED[k].cal != cal_loaded) begin
        load_calibration(CAL_SETS[DIRECTED[k].cal]);
        cal_loaded = DIRECTED[k].cal;
      end
      send_request(DIRECTED[k].p, DIRECTED[k].t, DIRECTED[k].known, DIRECTED[k].want);
    end

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: next_cal = CAL_SETS[CAL_MAX];
        1: next_cal = CAL_SETS[CAL_RESET];
        2: next_cal = CAL_SETS[CAL_TYPICAL];
        default: next_cal = pick_calibration();
      endcase
      load_calibration(next_cal);
      burst = $urandom_range(1, 40);
      for (int i = 0; i < 150; i++) begin
        if (ph == 3 && i == 75) begin
          pause_until_drained();
        end else if (burst == 0) begin
          gap = (ph == 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst = $urandom_range(1, 40);
        end
        send_request(pick_raw_pressure(), pick_raw_temp(cal_now), 1'b0, NO_READING);
        if (burst > 0) burst--;
      end
    end

    pause_until_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("PASS baro_pressure_temp_compensation");
    else
      $display("FAIL baro_pressure_temp_compensation");
    $finish;
  end

endmodule
